// File: rtl/polyline_circle_collision_top_defines.svh
// Assertion macros for the trail collision block checker.
// Used by pcc_checker.sv only; needs a clock and a reset signal in scope.
`ifndef POLYLINE_CIRCLE_COLLISION_TOP_DEFINES_SVH
`define POLYLINE_CIRCLE_COLLISION_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define PCC_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define PCC_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define PCC_CHECK_RST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pcc_pkg.sv
// Shared types and constants for the trail collision block.
// No dependencies.
`default_nettype none
package pcc_pkg;
   localparam int MAX_POINTS = 1024;
   localparam int ADDR_W     = 10;
   localparam int CNT_W      = 11;
   localparam int TAG_BITS   = 4;
   localparam int CRD_W      = 16;
   localparam int ACC_W      = 18;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int GRACE_W    = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_SPACING = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE   = 1'd1;

   localparam logic [ACC_W-1:0] ACC_MAX      = {ACC_W{1'b1}};
   localparam logic [CSR_DATA_W-1:0] SPACING_RESET = 16'd160;
   localparam logic [GRACE_W-1:0] GRACE_RESET = 10'd15;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      logic                    command;
      logic signed [CRD_W-1:0] pos_x;
      logic signed [CRD_W-1:0] pos_y;
      logic [CRD_W-1:0]        circle_radius;
      logic [TAG_BITS-1:0]     current_tag;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic             point_added;
      logic [CNT_W-1:0] point_count;
   } rsp_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]     tag;
      logic signed [CRD_W-1:0] y;
      logic signed [CRD_W-1:0] x;
   } point_type;

   localparam int POINT_W = $bits(point_type);

   typedef struct packed {
      logic signed [CRD_W-1:0] x0;
      logic signed [CRD_W-1:0] y0;
      logic signed [CRD_W-1:0] x1;
      logic signed [CRD_W-1:0] y1;
      logic signed [CRD_W-1:0] cx;
      logic signed [CRD_W-1:0] cy;
      logic [CRD_W-1:0]        r;
   } seg_in_type;

   typedef struct packed {
      logic done;
      logic hit;
   } seg_out_type;
endpackage
`default_nettype wire

// File: rtl/pcc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module pcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// File: rtl/pcc_isqrt.sv
// Step length unit: squares dx, dy on one multiplier, then a restoring
// integer square root, one result bit per cycle. Depends on pcc_pkg.
`default_nettype none
module pcc_isqrt
   import pcc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [16:0] dx,
   input  wire logic signed [16:0] dy,
   output logic                    done,
   output logic [16:0]             root
);
   typedef enum logic [2:0] {
      SQ_IDLE = 3'b001,
      SQ_MUL  = 3'b010,
      SQ_ITER = 3'b100
   } sq_state_type;

   sq_state_type      state_ff, state_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [33:0]       p_ff, p_in, rad_ff, rad_in;
   logic [19:0]       rem_ff, rem_in;
   logic [16:0]       root_ff, root_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic signed [16:0] m_op;
   logic signed [33:0] m_prod;
   logic [21:0]       rem_n, trial;

   assign m_op   = (cnt_ff == 5'd0) ? dx_ff : dy_ff;
   assign m_prod = m_op * m_op;
   assign rem_n  = {rem_ff, rad_ff[33:32]};
   assign trial  = {3'b000, root_ff, 2'b01};

   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      p_in     = p_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               dx_in    = dx;
               dy_in    = dy;
               cnt_in   = '0;
               state_in = SQ_MUL;
            end
         end
         SQ_MUL: begin
            p_in   = m_prod;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd1) begin
               rad_in = p_ff;
            end else if (cnt_ff == 5'd2) begin
               rad_in   = rad_ff + p_ff;
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = SQ_ITER;
            end
         end
         SQ_ITER: begin
            rad_in = {rad_ff[31:0], 2'b00};
            if (rem_n >= trial) begin
               rem_in  = 20'(rem_n - trial);
               root_in = {root_ff[15:0], 1'b1};
            end else begin
               rem_in  = rem_n[19:0];
               root_in = {root_ff[15:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               done_in  = 1'b1;
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      p_ff    <= p_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

// File: rtl/pcc_seg.sv
// Segment versus circle test on one shared 18x18 multiplier.
// Exact integer math; the final h^2 >= a*c check uses partial products.
// Depends on pcc_pkg.
`default_nettype none
module pcc_seg
   import pcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire seg_in_type  seg_in,
   output seg_out_type      seg_out
);
   typedef enum logic [5:0] {
      SG_IDLE = 6'b000001,
      SG_DIFF = 6'b000010,
      SG_MUL1 = 6'b000100,
      SG_DEC  = 6'b001000,
      SG_MUL2 = 6'b010000,
      SG_FIN  = 6'b100000
   } seg_state_type;

   seg_state_type      state_ff, state_in;
   seg_in_type         in_ff, in_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in, fx_ff, fx_in, fy_ff, fy_in;
   logic signed [35:0] a_ff, a_in, h_ff, h_in, c_ff, c_in, p_ff, p_in;
   logic [33:0]        uh_ff, uh_in;
   logic signed [69:0] big_ff, big_in;
   logic [3:0]         k_ff, k_in, pk_ff, pk_in;
   logic               pv_ff, pv_in;
   logic               done_ff, done_in, hit_ff, hit_in;

   logic signed [17:0] ma, mb;
   logic signed [35:0] prod;
   logic signed [69:0] pext, pshift;
   logic signed [37:0] g1;
   logic signed [35:0] nh;

   always_comb begin
      case (k_ff)
         4'd0:    begin ma = {dx_ff[16], dx_ff}; mb = {dx_ff[16], dx_ff}; end
         4'd1:    begin ma = {dy_ff[16], dy_ff}; mb = {dy_ff[16], dy_ff}; end
         4'd2:    begin ma = {fx_ff[16], fx_ff}; mb = {dx_ff[16], dx_ff}; end
         4'd3:    begin ma = {fy_ff[16], fy_ff}; mb = {dy_ff[16], dy_ff}; end
         4'd4:    begin ma = {fx_ff[16], fx_ff}; mb = {fx_ff[16], fx_ff}; end
         4'd5:    begin ma = {fy_ff[16], fy_ff}; mb = {fy_ff[16], fy_ff}; end
         4'd6:    begin ma = {2'b00, in_ff.r};   mb = {2'b00, in_ff.r};   end
         4'd7:    begin ma = {1'b0, uh_ff[16:0]};  mb = {1'b0, uh_ff[16:0]};  end
         4'd8:    begin ma = {1'b0, uh_ff[16:0]};  mb = {1'b0, uh_ff[33:17]}; end
         4'd9:    begin ma = {1'b0, uh_ff[33:17]}; mb = {1'b0, uh_ff[16:0]};  end
         4'd10:   begin ma = {1'b0, uh_ff[33:17]}; mb = {1'b0, uh_ff[33:17]}; end
         4'd11:   begin ma = {1'b0, a_ff[16:0]};   mb = {1'b0, c_ff[16:0]};   end
         4'd12:   begin ma = {1'b0, a_ff[16:0]};   mb = {1'b0, c_ff[33:17]};  end
         4'd13:   begin ma = {1'b0, a_ff[33:17]};  mb = {1'b0, c_ff[16:0]};   end
         4'd14:   begin ma = {1'b0, a_ff[33:17]};  mb = {1'b0, c_ff[33:17]};  end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   assign prod = ma * mb;
   assign pext = {{34{p_ff[35]}}, p_ff};

   always_comb begin
      case (pk_ff)
         4'd8, 4'd9, 4'd12, 4'd13: pshift = pext <<< 17;
         4'd10, 4'd14:             pshift = pext <<< 34;
         default:                  pshift = pext;
      endcase
   end

   assign g1 = {{2{a_ff[35]}}, a_ff} + {h_ff[35], h_ff, 1'b0} + {{2{c_ff[35]}}, c_ff};
   assign nh = -h_ff;

   always_comb begin
      state_in = state_ff;
      in_in    = in_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      fx_in    = fx_ff;
      fy_in    = fy_ff;
      a_in     = a_ff;
      h_in     = h_ff;
      c_in     = c_ff;
      uh_in    = uh_ff;
      big_in   = big_ff;
      k_in     = k_ff;
      pk_in    = pk_ff;
      pv_in    = 1'b0;
      p_in     = p_ff;
      done_in  = 1'b0;
      hit_in   = hit_ff;

      // fold the product issued last cycle
      if (pv_ff) begin
         case (pk_ff)
            4'd0, 4'd1: a_in = a_ff + p_ff;
            4'd2, 4'd3: h_in = h_ff + p_ff;
            4'd4, 4'd5: c_in = c_ff + p_ff;
            4'd6:       c_in = c_ff - p_ff;
            4'd7, 4'd8, 4'd9, 4'd10: big_in = big_ff + pshift;
            default:    big_in = big_ff - pshift;
         endcase
      end

      unique case (state_ff)
         SG_IDLE: begin
            if (start) begin
               in_in    = seg_in;
               state_in = SG_DIFF;
            end
         end
         SG_DIFF: begin
            dx_in    = {in_ff.x1[15], in_ff.x1} - {in_ff.x0[15], in_ff.x0};
            dy_in    = {in_ff.y1[15], in_ff.y1} - {in_ff.y0[15], in_ff.y0};
            fx_in    = {in_ff.x0[15], in_ff.x0} - {in_ff.cx[15], in_ff.cx};
            fy_in    = {in_ff.y0[15], in_ff.y0} - {in_ff.cy[15], in_ff.cy};
            a_in     = '0;
            h_in     = '0;
            c_in     = '0;
            k_in     = '0;
            state_in = SG_MUL1;
         end
         SG_MUL1: begin
            if (k_ff < 4'd7) begin
               p_in  = prod;
               pk_in = k_ff;
               pv_in = 1'b1;
               k_in  = k_ff + 4'd1;
            end else begin
               state_in = SG_DEC;
            end
         end
         SG_DEC: begin
            big_in = '0;
            uh_in  = nh[33:0];
            if (a_ff == '0) begin
               done_in = 1'b1; hit_in = 1'b0; state_in = SG_IDLE;
            end else if (c_ff == '0 || g1 == '0) begin
               done_in = 1'b1; hit_in = 1'b1; state_in = SG_IDLE;
            end else if (c_ff[35] != g1[37]) begin
               done_in = 1'b1; hit_in = 1'b1; state_in = SG_IDLE;
            end else if (c_ff[35]) begin
               // both ends inside
               done_in = 1'b1; hit_in = 1'b0; state_in = SG_IDLE;
            end else if (h_ff > 36'sd0 || nh > a_ff) begin
               // vertex outside [0,1]
               done_in = 1'b1; hit_in = 1'b0; state_in = SG_IDLE;
            end else begin
               state_in = SG_MUL2;
            end
         end
         SG_MUL2: begin
            if (k_ff < 4'd15) begin
               p_in  = prod;
               pk_in = k_ff;
               pv_in = 1'b1;
               k_in  = k_ff + 4'd1;
            end else begin
               state_in = SG_FIN;
            end
         end
         SG_FIN: begin
            done_in  = 1'b1;
            hit_in   = ~big_ff[69];
            state_in = SG_IDLE;
         end
         default: state_in = SG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SG_IDLE;
         pv_ff    <= 1'b0;
         done_ff  <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= pv_in;
         done_ff  <= done_in;
         k_ff     <= k_in;
      end
      in_ff  <= in_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      fx_ff  <= fx_in;
      fy_ff  <= fy_in;
      a_ff   <= a_in;
      h_ff   <= h_in;
      c_ff   <= c_in;
      uh_ff  <= uh_in;
      big_ff <= big_in;
      pk_ff  <= pk_in;
      p_ff   <= p_in;
      hit_ff <= hit_in;
   end

   assign seg_out.done = done_ff;
   assign seg_out.hit  = hit_ff;
endmodule
`default_nettype wire

// File: rtl/polyline_circle_collision_top.sv
// Trail recorder with circle collision query, one item at a time.
// Update with tag 0 goes straight to the result. Update with tag runs the
// square root unit, one bit per cycle. Query walks the stored segments
// through the segment unit (shared multiplier in the segment unit); a hit ends it.
// Sync reset clears count, accumulator, last position, registers; the point
// store keeps its contents and is never read beyond the count.
`default_nettype none
module polyline_circle_collision_top
   import pcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   typedef enum logic [5:0] {
      T_IDLE = 6'b000001,
      T_SQRT = 6'b000010,
      T_Q0   = 6'b000100,
      T_QCHK = 6'b001000,
      T_SEG  = 6'b010000,
      T_OUT  = 6'b100000
   } top_state_type;

   top_state_type           state_ff, state_in;
   req_type                 item_ff, item_in;
   logic [CSR_DATA_W-1:0]   thr_ff;
   logic [GRACE_W-1:0]      grace_ff;
   logic [CNT_W-1:0]        count_ff, count_in, idx_ff, idx_in, end_ff, end_in;
   logic signed [CRD_W-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   point_type               prev_ff, prev_in, cur_ff, cur_in;
   rsp_type                 res_ff, res_in, out_ff;
   logic                    out_v_ff;

   logic                    accept, out_take, out_load;
   logic                    sq_start, sq_done;
   logic [16:0]             sq_root;
   logic signed [16:0]      sq_dx, sq_dy;
   logic                    seg_start;
   seg_in_type              seg_in;
   seg_out_type             seg_out;
   logic                    mem_we;
   point_type               mem_wdata, mem_rdata;
   logic [ACC_W:0]          acc_sum;
   logic [ACC_W-1:0]        acc_sat;
   logic [CNT_W-1:0]        idx_nxt;
   logic                    both_tag;

   assign accept   = req_valid & ~req_stall;
   assign req_stall = (state_ff != T_IDLE);
   assign out_take = out_v_ff & ~rsp_stall;
   assign out_load = (state_ff == T_OUT) & (~out_v_ff | ~rsp_stall);

   assign sq_dx = {item_ff.pos_x[15], item_ff.pos_x} - {last_x_ff[15], last_x_ff};
   assign sq_dy = {item_ff.pos_y[15], item_ff.pos_y} - {last_y_ff[15], last_y_ff};

   assign acc_sum = {1'b0, acc_ff} + {2'b00, sq_root};
   assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
   assign idx_nxt = idx_ff + 11'd1;
   assign both_tag = (mem_rdata.tag == item_ff.current_tag) &&
                     (prev_ff.tag == item_ff.current_tag);

   assign seg_in.x0 = prev_ff.x;
   assign seg_in.y0 = prev_ff.y;
   assign seg_in.x1 = mem_rdata.x;
   assign seg_in.y1 = mem_rdata.y;
   assign seg_in.cx = item_ff.pos_x;
   assign seg_in.cy = item_ff.pos_y;
   assign seg_in.r  = item_ff.circle_radius;

   assign mem_wdata.tag = item_ff.current_tag;
   assign mem_wdata.x   = item_ff.pos_x;
   assign mem_wdata.y   = item_ff.pos_y;

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      end_in    = end_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      acc_in    = acc_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      res_in    = res_ff;
      sq_start  = 1'b0;
      seg_start = 1'b0;
      mem_we    = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               item_in = req_payload;
               res_in  = '{hit: 1'b0, point_added: 1'b0, point_count: count_ff};
               idx_in  = '0;
               end_in  = count_ff - {1'b0, grace_ff};
               if (req_payload.command == CMD_UPDATE) begin
                  if (req_payload.current_tag == '0) begin
                     acc_in   = '0;
                     state_in = T_OUT;
                  end else begin
                     state_in = T_SQRT;
                  end
               end else if (count_ff > 11'd1 && count_ff > {1'b0, grace_ff} &&
                            (count_ff - {1'b0, grace_ff}) > 11'd1) begin
                  state_in = T_Q0;
               end else begin
                  state_in = T_OUT;
               end
            end
         end
         T_SQRT: begin
            // start pulse on entry, done comes back later
            sq_start = ~sq_done & (idx_ff == '0);
            idx_in   = 11'd1;
            if (sq_done) begin
               last_x_in = item_ff.pos_x;
               last_y_in = item_ff.pos_y;
               if (acc_sat > {2'b00, thr_ff}) begin
                  acc_in = '0;
                  if (count_ff < 11'(MAX_POINTS)) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + 11'd1;
                     res_in   = '{hit: 1'b0, point_added: 1'b1, point_count: count_in};
                  end
               end else begin
                  acc_in = acc_sat;
               end
               state_in = T_OUT;
            end
         end
         T_Q0: begin
            prev_in  = mem_rdata;
            idx_in   = 11'd1;
            state_in = T_QCHK;
         end
         T_QCHK: begin
            if (both_tag) begin
               prev_in = mem_rdata;
               idx_in  = idx_nxt;
               if (idx_nxt >= end_ff) begin
                  state_in = T_OUT;
               end
            end else begin
               cur_in    = mem_rdata;
               seg_start = 1'b1;
               state_in  = T_SEG;
            end
         end
         T_SEG: begin
            if (seg_out.done) begin
               if (seg_out.hit) begin
                  res_in.hit = 1'b1;
                  state_in   = T_OUT;
               end else begin
                  prev_in  = cur_ff;
                  idx_in   = idx_nxt;
                  state_in = (idx_nxt >= end_ff) ? T_OUT : T_QCHK;
               end
            end
         end
         T_OUT: begin
            if (out_load) begin
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= T_IDLE;
         count_ff  <= '0;
         acc_ff    <= '0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         thr_ff    <= SPACING_RESET;
         grace_ff  <= GRACE_RESET;
         out_v_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         idx_ff    <= idx_in;
         if (out_load) begin
            out_v_ff <= 1'b1;
         end else if (out_take) begin
            out_v_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_SPACING: thr_ff   <= csr_wdata;
               CSR_GRACE:   grace_ff <= csr_wdata[GRACE_W-1:0];
               default:     ;
            endcase
         end
      end
      item_ff <= item_in;
      end_ff  <= end_in;
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      res_ff  <= res_in;
      if (out_load) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

   pcc_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .dx    (sq_dx),
      .dy    (sq_dy),
      .done  (sq_done),
      .root  (sq_root)
   );

   pcc_seg u_seg (
      .clock   (clock),
      .reset   (reset),
      .start   (seg_start),
      .seg_in  (seg_in),
      .seg_out (seg_out)
   );

   // read address follows the next segment index
   pcc_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_points (
      .clock (clock),
      .we    (mem_we),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata (mem_wdata),
      .raddr (idx_in[ADDR_W-1:0]),
      .rdata (mem_rdata)
   );
endmodule
`default_nettype wire

// File: rtl/pcc_checker.sv
// Port-level checks for the trail collision block, bound to the top level.
// Depends on pcc_pkg and polyline_circle_collision_top_defines.svh.
`default_nettype none
`include "polyline_circle_collision_top_defines.svh"
module pcc_checker
   import pcc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);
   `PCC_CHECK_RST(a_rst_idle, reset, !rsp_valid, "result valid right after reset")
   `PCC_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result dropped or changed")
   `PCC_CHECK_NOW(a_cnt_max, rsp_valid, rsp_payload.point_count <= CNT_W'(MAX_POINTS), "point count beyond store size")
   `PCC_CHECK_NOW(a_kind, rsp_valid, !(rsp_payload.hit && rsp_payload.point_added), "hit and point added in one result")
   `PCC_CHECK_NEXT(a_one_item, req_valid && !req_stall, req_stall, "second transfer taken while busy")
endmodule

bind polyline_circle_collision_top pcc_checker u_chk (.*);
`default_nettype wire
